// ===== design/rgsh_pkg.sv =====
// Package for the random grain sample-and-hold block.
// Holds shared constants, the controller state type and the command/status structs.
// No dependencies.
`default_nettype none
package rgsh_pkg;

	// default sizing of the grain store
	localparam int MAX_BINS_DEF  = 8;
	localparam int MAX_GRAIN_DEF = 16384;
	localparam int FADE_LEN_DEF  = 50;

	// configuration registers
	localparam int NB_W      = 4;
	localparam int GS_W      = 15;
	localparam int CFG_W     = 15;
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_BINS      = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRAIN_SAMPLES = 1'd1;
	localparam logic [NB_W-1:0]      NB_RST            = 4'd8;
	localparam logic [GS_W-1:0]      GS_RST            = 15'd9600;

	// stream payloads
	localparam int SAMPLE_W    = 16;
	localparam int RND_W       = 32;
	localparam int WORD_W      = 32;
	localparam int IN_TDATA_W  = 64;
	localparam int OUT_TDATA_W = 32;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MOD,
		ST_RD_PLAY,
		ST_RD_TAIL,
		ST_OUT,
		ST_WR_TAIL,
		ST_INC,
		ST_CHK,
		ST_FD_RD,
		ST_FD_MUL,
		ST_FD_ABS,
		ST_FD_RCP,
		ST_FD_COR,
		ST_FD_WR,
		ST_SWAP,
		ST_END,
		ST_SRCH
	} state_t;

	typedef enum logic [1:0] {
		RD_PLAY,
		RD_TAIL,
		RD_FADE
	} rd_sel_t;

	typedef enum logic [2:0] {
		WR_NONE,
		WR_CLEAR,
		WR_REC,
		WR_TAIL,
		WR_FADE
	} wr_sel_t;

	typedef struct packed {
		logic    cap_in;
		logic    mod_step;
		logic    set_first;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    cap_play;
		logic    load_out;
		wr_sel_t wr_sel;
		logic    pos_inc;
		logic    fd_init;
		logic    fd_mul;
		logic    fd_abs;
		logic    fd_rcp;
		logic    fd_cor;
		logic    fd_next;
		logic    swap;
		logic    grain_end;
		logic    srch_step;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic mod_done;
		logic out_free;
		logic pos_lt_f;
		logic pos_eq_f;
		logic grain_end;
		logic fd_last;
		logic srch_done;
	} status_t;

endpackage
`default_nettype wire

// ===== design/rgsh_ctrl.sv =====
// Controller for the random grain sample-and-hold block.
// Sequences clear, modulo, read/write, fade and bin search steps; uses rgsh_pkg.
`default_nettype none
module rgsh_ctrl
	import rgsh_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	input  wire status_t st,
	output cmd_t         cmd
);

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR:   if (st.clr_last) state_d = ST_IDLE;
			ST_IDLE:    if (in_valid) state_d = ST_MOD;
			ST_MOD:     if (st.mod_done) state_d = ST_RD_PLAY;
			ST_RD_PLAY: state_d = ST_RD_TAIL;
			ST_RD_TAIL: state_d = ST_OUT;
			ST_OUT:     if (st.out_free) state_d = ST_WR_TAIL;
			ST_WR_TAIL: state_d = ST_INC;
			ST_INC:     state_d = ST_CHK;
			ST_CHK: begin
				if (st.pos_eq_f) state_d = ST_FD_RD;
				else if (st.grain_end) state_d = ST_END;
				else state_d = ST_IDLE;
			end
			ST_FD_RD:   state_d = ST_FD_MUL;
			ST_FD_MUL:  state_d = ST_FD_ABS;
			ST_FD_ABS:  state_d = ST_FD_RCP;
			ST_FD_RCP:  state_d = ST_FD_COR;
			ST_FD_COR:  state_d = ST_FD_WR;
			ST_FD_WR:   state_d = st.fd_last ? ST_SWAP : ST_FD_RD;
			ST_SWAP:    state_d = st.grain_end ? ST_END : ST_IDLE;
			ST_END:     state_d = ST_SRCH;
			ST_SRCH:    if (st.srch_done) state_d = ST_IDLE;
			default:    state_d = ST_CLEAR;
		endcase
	end

	// command outputs
	always_comb begin
		cmd      = '0;
		cmd.rd_sel = RD_PLAY;
		cmd.wr_sel = WR_NONE;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: cmd.wr_sel = WR_CLEAR;
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.cap_in = in_valid;
			end
			ST_MOD: begin
				cmd.mod_step  = !st.mod_done;
				cmd.set_first = st.mod_done;
			end
			ST_RD_PLAY: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_PLAY;
			end
			ST_RD_TAIL: begin
				cmd.rd_en    = 1'b1;
				cmd.rd_sel   = RD_TAIL;
				cmd.cap_play = 1'b1;
			end
			ST_OUT: begin
				cmd.load_out = st.out_free;
				cmd.wr_sel   = st.out_free ? WR_REC : WR_NONE;
			end
			ST_WR_TAIL: cmd.wr_sel = st.pos_lt_f ? WR_TAIL : WR_NONE;
			ST_INC:     cmd.pos_inc = 1'b1;
			ST_CHK:     cmd.fd_init = st.pos_eq_f;
			ST_FD_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_FADE;
			end
			ST_FD_MUL: cmd.fd_mul = 1'b1;
			ST_FD_ABS: cmd.fd_abs = 1'b1;
			ST_FD_RCP: cmd.fd_rcp = 1'b1;
			ST_FD_COR: cmd.fd_cor = 1'b1;
			ST_FD_WR: begin
				cmd.wr_sel  = WR_FADE;
				cmd.fd_next = 1'b1;
			end
			ST_SWAP: cmd.swap = 1'b1;
			ST_END:  cmd.grain_end = 1'b1;
			ST_SRCH: cmd.srch_step = 1'b1;
			default: cmd.wr_sel = WR_NONE;
		endcase
	end

endmodule
`default_nettype wire

// ===== design/rgsh_dp.sv =====
// Datapath for the random grain sample-and-hold block: grain store, bin and
// position registers, modulo unit, fade scaler and output register; uses rgsh_pkg.
`default_nettype none
module rgsh_dp
	import rgsh_pkg::*;
#(
	parameter int MAX_BINS  = MAX_BINS_DEF,
	parameter int MAX_GRAIN = MAX_GRAIN_DEF,
	parameter int FADE_LEN  = FADE_LEN_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   wr_en,
	input  wire logic [CFG_IDX_W-1:0]   wr_index,
	input  wire logic [CFG_W-1:0]       wr_data,
	input  wire logic [IN_TDATA_W-1:0]  in_data,
	input  wire logic                   out_ready,
	output logic                        out_valid,
	output logic [OUT_TDATA_W-1:0]      out_data,
	input  wire cmd_t                   cmd,
	output status_t                     st
);

	localparam int STRIDE = MAX_GRAIN + FADE_LEN;
	localparam int DEPTH  = MAX_BINS * STRIDE;
	localparam int AW     = $clog2(DEPTH);
	localparam int BW     = $clog2(MAX_BINS + 1);
	localparam int BIDX   = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
	localparam int GW     = $clog2(MAX_GRAIN + 1);
	localparam int KW     = $clog2(FADE_LEN);
	localparam int MW     = SAMPLE_W + KW;
	localparam int PW     = MW + 1;
	localparam int SH     = MW + 1;
	localparam int RECIP  = (2 ** SH) / FADE_LEN;
	localparam int CNT_W  = $clog2(RND_W + 1);
	localparam int GS_LO  = 2 * FADE_LEN + 1;
	localparam logic [MW-1:0] F_M = MW'(FADE_LEN);

	// configuration registers
	logic [NB_W-1:0] num_bins_q;
	logic [GS_W-1:0] grain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_bins_q <= NB_RST;
			grain_q    <= GS_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_NUM_BINS:      num_bins_q <= wr_data[NB_W-1:0];
				REG_GRAIN_SAMPLES: grain_q    <= wr_data[GS_W-1:0];
				default:           ;
			endcase
		end
	end

	// effective (clamped) bin count and grain length
	logic [7:0]    nbx;
	logic [BW-1:0] nb;
	logic [17:0]   gx;
	logic [GW-1:0] gs;

	always_comb begin
		nbx = 8'(num_bins_q);
		if (nbx == 8'd0) nb = BW'(1);
		else if (nbx > 8'(MAX_BINS)) nb = BW'(MAX_BINS);
		else nb = BW'(nbx);
		gx = 18'(grain_q);
		if (gx < 18'(GS_LO)) gs = GW'(GS_LO);
		else if (gx > 18'(MAX_GRAIN)) gs = GW'(MAX_GRAIN);
		else gs = GW'(gx);
	end

	// control state
	logic [BIDX-1:0]     play_q, ptail_q, rec_q, rtail_q, cand_q, mod_q;
	logic [GW-1:0]       pos_q;
	logic                first_q;
	logic [MAX_BINS-1:0] written_q;
	logic [AW-1:0]       clr_q;
	logic [KW-1:0]       k_q;
	logic                sel_q;
	logic [BW-1:0]       n_q, rem_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                out_valid_q;

	// payload registers
	logic [RND_W-1:0]    rnd_q;
	logic [WORD_W-1:0]   in_w_q, play_w_q, rdata_q, fd_w_q;
	logic [SAMPLE_W-1:0] out_l_q, out_r_q;
	logic signed [PW-1:0] prod_q [2];
	logic [MW-1:0]       mag_q [2];
	logic                neg_q [2];
	logic [MW-1:0]       q0_q [2];

	// modulo unit: one quotient bit per step
	logic [BW:0]   rem2;
	logic [BW:0]   rem_n;
	always_comb begin
		rem2  = {rem_q, rnd_q[RND_W-1]};
		rem_n = (rem2 >= (BW+1)'(nb)) ? rem2 - (BW+1)'(nb) : rem2;
	end
	assign mod_q = BIDX'(rem_q);

	// status flags
	logic [31:0] pos32;
	assign pos32 = 32'(pos_q);

	// next-bin search step
	logic [BIDX:0]   nxt_w;
	logic [BIDX-1:0] nxt;
	logic            found, exhausted;
	always_comb begin
		nxt_w     = {1'b0, cand_q} + (BIDX+1)'(1);
		nxt       = (8'(nxt_w) >= 8'(nb)) ? '0 : nxt_w[BIDX-1:0];
		found     = written_q[nxt];
		exhausted = (8'(n_q) + 8'd1) == 8'(nb);
	end

	always_comb begin
		st.clr_last  = clr_q == AW'(DEPTH - 1);
		st.mod_done  = cnt_q == CNT_W'(RND_W);
		st.out_free  = !out_valid_q || out_ready;
		st.pos_lt_f  = pos32 < 32'(FADE_LEN);
		st.pos_eq_f  = pos32 == 32'(FADE_LEN);
		st.grain_end = pos_q >= gs;
		st.fd_last   = sel_q && (k_q == KW'(FADE_LEN - 1));
		st.srch_done = found || exhausted;
	end

	// control register updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			play_q      <= '0;
			ptail_q     <= '0;
			rec_q       <= '0;
			rtail_q     <= '0;
			cand_q      <= '0;
			pos_q       <= '0;
			first_q     <= 1'b1;
			written_q   <= '0;
			clr_q       <= '0;
			k_q         <= '0;
			sel_q       <= 1'b0;
			n_q         <= '0;
			rem_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.wr_sel == WR_CLEAR) clr_q <= clr_q + AW'(1);
			if (cmd.cap_in) begin
				rem_q <= '0;
				cnt_q <= '0;
			end
			if (cmd.mod_step) begin
				rem_q <= BW'(rem_n);
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd.set_first && first_q) begin
				rec_q   <= mod_q;
				first_q <= 1'b0;
			end
			if (cmd.pos_inc) pos_q <= pos_q + GW'(1);
			if (cmd.fd_init) begin
				k_q   <= '0;
				sel_q <= 1'b0;
			end
			if (cmd.fd_next) begin
				sel_q <= !sel_q;
				if (sel_q) k_q <= k_q + KW'(1);
			end
			if (cmd.swap) begin
				rtail_q <= rec_q;
				ptail_q <= play_q;
			end
			if (cmd.grain_end) begin
				written_q[rec_q] <= 1'b1;
				rec_q            <= mod_q;
				pos_q            <= '0;
				cand_q           <= play_q;
				n_q              <= '0;
			end
			if (cmd.srch_step) begin
				if (found) play_q <= nxt;
				else if (exhausted) play_q <= '0;
				else begin
					cand_q <= nxt;
					n_q    <= n_q + BW'(1);
				end
			end
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// store addresses
	logic [AW-1:0] play_base, ptail_base, rec_base, rtail_base;
	logic [AW-1:0] pos_a, gs_a, k_a, rd_addr, wr_addr;
	logic [WORD_W-1:0] wr_word;
	logic              we;

	always_comb begin
		play_base  = AW'(play_q) * AW'(STRIDE);
		ptail_base = AW'(ptail_q) * AW'(STRIDE);
		rec_base   = AW'(rec_q) * AW'(STRIDE);
		rtail_base = AW'(rtail_q) * AW'(STRIDE);
		pos_a      = AW'(pos_q);
		gs_a       = AW'(gs);
		k_a        = AW'(k_q);
		case (cmd.rd_sel)
			RD_PLAY: rd_addr = play_base + pos_a;
			RD_TAIL: rd_addr = ptail_base + gs_a + pos_a;
			RD_FADE: rd_addr = sel_q ? rtail_base + gs_a + k_a : rec_base + k_a;
			default: rd_addr = '0;
		endcase
		we      = 1'b1;
		wr_addr = '0;
		wr_word = in_w_q;
		case (cmd.wr_sel)
			WR_CLEAR: begin
				wr_addr = clr_q;
				wr_word = '0;
			end
			WR_REC:  wr_addr = rec_base + pos_a;
			WR_TAIL: wr_addr = rtail_base + gs_a + pos_a;
			WR_FADE: begin
				wr_addr = sel_q ? rtail_base + gs_a + k_a : rec_base + k_a;
				wr_word = fd_w_q;
			end
			default: we = 1'b0;
		endcase
	end

	// grain store, registered read
	logic [WORD_W-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[wr_addr] <= wr_word;
		if (cmd.rd_en) rdata_q <= mem[rd_addr];
	end

	// fade scaler: s*k, magnitude, reciprocal multiply, one-step correction
	logic [KW-1:0]       fac;
	logic [MW+SH-1:0]    qp [2];
	logic [MW-1:0]       rr [2];
	logic [MW-1:0]       qq [2];
	logic [MW-1:0]       qs [2];
	logic [SAMPLE_W-1:0] samp [2];
	always_comb begin
		fac     = sel_q ? KW'(FADE_LEN - 1) - k_q : k_q;
		samp[0] = rdata_q[31:16];
		samp[1] = rdata_q[15:0];
		for (int i = 0; i < 2; i++) begin
			qp[i] = (MW+SH)'(mag_q[i]) * (MW+SH)'(RECIP);
			rr[i] = mag_q[i] - q0_q[i] * F_M;
			qq[i] = (rr[i] >= F_M) ? q0_q[i] + MW'(1) : q0_q[i];
			qs[i] = neg_q[i] ? -qq[i] : qq[i];
		end
	end

	// output sum with saturation
	logic signed [SAMPLE_W:0]   sum_l, sum_r;
	logic signed [SAMPLE_W-1:0] sat_l, sat_r, o_l, o_r;
	always_comb begin
		sum_l = 17'(signed'(play_w_q[31:16])) + 17'(signed'(rdata_q[31:16]));
		sum_r = 17'(signed'(play_w_q[15:0])) + 17'(signed'(rdata_q[15:0]));
		sat_l = (sum_l > 17'sd32767) ? 16'sh7fff :
			(sum_l < -17'sd32768) ? 16'sh8000 : sum_l[15:0];
		sat_r = (sum_r > 17'sd32767) ? 16'sh7fff :
			(sum_r < -17'sd32768) ? 16'sh8000 : sum_r[15:0];
		o_l = st.pos_lt_f ? sat_l : play_w_q[31:16];
		o_r = st.pos_lt_f ? sat_r : play_w_q[15:0];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			in_w_q <= {in_data[15:0], in_data[31:16]};
			rnd_q  <= in_data[63:32];
		end
		if (cmd.mod_step) rnd_q <= {rnd_q[RND_W-2:0], 1'b0};
		if (cmd.cap_play) play_w_q <= rdata_q;
		if (cmd.load_out) begin
			out_l_q <= o_l;
			out_r_q <= o_r;
		end
		for (int i = 0; i < 2; i++) begin
			if (cmd.fd_mul) prod_q[i] <= $signed(samp[i]) * $signed({1'b0, fac});
			if (cmd.fd_abs) begin
				neg_q[i] <= prod_q[i][PW-1];
				mag_q[i] <= prod_q[i][PW-1] ? MW'(-prod_q[i]) : MW'(prod_q[i]);
			end
			if (cmd.fd_rcp) q0_q[i] <= qp[i][MW+SH-1:SH];
		end
		if (cmd.fd_cor) fd_w_q <= {qs[0][15:0], qs[1][15:0]};
	end

	assign out_valid = out_valid_q;
	assign out_data  = {out_r_q, out_l_q};

endmodule
`default_nettype wire

// ===== design/random_grain_sample_hold.sv =====
// Randomized stereo grain sample-and-hold. Each input beat gives one output beat.
// After reset a clearing pass zeroes the grain store, MAX_BINS*(MAX_GRAIN+FADE_LEN)
// words (131472 at the defaults), during which no input beat is taken. An item
// then runs the 32-step modulo of random_word and the single-port grain store
// read/write sequence; the item that brings the position to FADE_LEN adds
// 2*FADE_LEN read-scale-write passes through the read, multiply, magnitude,
// reciprocal, correction and write states, and a grain end adds the written-bin
// search. One item is in work at a time; a finished output beat waits in its
// register while the next input is taken. Depends on rgsh_pkg, rgsh_ctrl and rgsh_dp.
`default_nettype none
module random_grain_sample_hold
	import rgsh_pkg::*;
#(
	parameter int MAX_BINS  = MAX_BINS_DEF,
	parameter int MAX_GRAIN = MAX_GRAIN_DEF,
	parameter int FADE_LEN  = FADE_LEN_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   wr_en,
	input  wire logic [CFG_IDX_W-1:0]   wr_index,
	input  wire logic [CFG_W-1:0]       wr_data,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	// in_left [15:0], in_right [31:16], random_word [63:32]
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	// out_left [15:0], out_right [31:16]
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

	cmd_t    cmd;
	status_t st;

	rgsh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.st       (st),
		.cmd      (cmd)
	);

	rgsh_dp #(
		.MAX_BINS  (MAX_BINS),
		.MAX_GRAIN (MAX_GRAIN),
		.FADE_LEN  (FADE_LEN)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.in_data   (s_axis_tdata),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_data  (m_axis_tdata),
		.cmd       (cmd),
		.st        (st)
	);

`ifndef ASSERT_OFF
	// one item in work at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input taken while an item is in work");

	// no input during the clearing pass
	a_clear_block: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_sel == WR_CLEAR) |-> !s_axis_tready)
		else $error("input ready during store clear");

	// output register loaded only when free
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!m_axis_tvalid || m_axis_tready))
		else $error("output beat overwritten");
`endif

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for random_grain_sample_hold: stereo beats in, one stereo beat out per beat in.
// Holds its own grain-store predictor and checks every output beat against it.
// Depends on rgsh_pkg and the random_grain_sample_hold RTL.
`default_nettype none
module tb_top;
	import rgsh_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BINS   = 8;
	localparam int GRAIN  = 16384;
	localparam int FADE   = 50;
	localparam int STRIDE = GRAIN + FADE;
	localparam int IDLE_LIMIT = 600000;   // covers the clearing pass after reset

	typedef struct {
		logic [15:0] left;
		logic [15:0] right;
		logic [31:0] rnd;
	} grain_in_t;

	typedef struct {
		logic [15:0] left;
		logic [15:0] right;
	} stereo_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] wr_index = REG_NUM_BINS;
	logic [CFG_W-1:0] wr_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	random_grain_sample_hold dut (.*);

	always #1 clk = ~clk;

	// pending input beats and expected output samples
	grain_in_t pending_q[$];
	stereo_t   expected_q[$];
	grain_in_t cur_item;
	int errors = 0;
	int beats_in = 0;
	int beats_out = 0;
	int grains_done = 0;

	// mirrored registers and grain state
	logic [3:0]  nb_reg = NB_RST;
	logic [14:0] gs_reg = GS_RST;
	logic [31:0] store[0:BINS*STRIDE-1];
	bit   [BINS-1:0] written = '0;
	int play_b = 0, play_tail_b = 0, rec_b = 0, rec_tail_b = 0, position = 0;
	bit first_pending = 1;

	function automatic int store_addr(int bin, int idx);
		return bin * STRIDE + idx;
	endfunction

	function automatic int sat16(int v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	// multiply both channels by k/FADE, truncating toward zero
	function automatic void fade_word(int a, int k);
		int l, r;
		l = $signed(store[a][31:16]);
		r = $signed(store[a][15:0]);
		l = (l * k) / FADE;
		r = (r * k) / FADE;
		store[a] = {l[15:0], r[15:0]};
	endfunction

	function automatic void predict_grain_out(grain_in_t it);
		int nb, gs, l, r, c, k;
		bit found;
		logic [31:0] p, t;
		stereo_t o;
		nb = (nb_reg < 1) ? 1 : (nb_reg > BINS) ? BINS : nb_reg;
		gs = (gs_reg < 2*FADE+1) ? 2*FADE+1 : (gs_reg > GRAIN) ? GRAIN : gs_reg;
		if (first_pending) begin
			rec_b = int'(it.rnd % 32'(nb));
			first_pending = 0;
		end
		// read before write: play bin plus overlap tail
		p = store[store_addr(play_b, position)];
		l = $signed(p[31:16]);
		r = $signed(p[15:0]);
		if (position < FADE) begin
			t = store[store_addr(play_tail_b, gs + position)];
			l = sat16(l + $signed(t[31:16]));
			r = sat16(r + $signed(t[15:0]));
		end
		o.left = l[15:0];
		o.right = r[15:0];
		expected_q.push_back(o);
		// record
		store[store_addr(rec_b, position)] = {it.left, it.right};
		if (position < FADE)
			store[store_addr(rec_tail_b, gs + position)] = {it.left, it.right};
		position++;
		// crossfade at end of overlap
		if (position == FADE) begin
			for (k = 0; k < FADE; k++) begin
				fade_word(store_addr(rec_b, k), k);
				fade_word(store_addr(rec_tail_b, gs + k), FADE - 1 - k);
			end
			rec_tail_b = rec_b;
			play_tail_b = play_b;
		end
		// grain end: new record bin, advance playback to next written bin
		if (position >= gs) begin
			grains_done++;
			written[rec_b] = 1;
			rec_b = int'(it.rnd % 32'(nb));
			c = play_b;
			found = 0;
			for (k = 0; k < nb; k++) begin
				c = (c + 1 >= nb) ? 0 : c + 1;
				if (written[c]) begin
					found = 1;
					break;
				end
			end
			play_b = found ? c : 0;
			position = 0;
		end
	endfunction

	// sender: bursts and gaps, holds off on request
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_grain_out(cur_item);
				beats_in++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_axis_tvalid <= 1'b0;
				end else if (pending_q.size() > 0) begin
					cur_item = pending_q.pop_front();
					s_axis_tdata <= {cur_item.rnd, cur_item.right, cur_item.left};
					s_axis_tvalid <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
						gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 120);
					end
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: stall pattern plus one long hold-off
	int stall_phase = 0;
	int hold_left = 0;
	bit hold_done = 0;
	always @(posedge clk or negedge arst_n) begin
		stereo_t e;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				beats_out++;
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected beat %h", $time, m_axis_tdata);
					errors++;
				end else begin
					e = expected_q.pop_front();
					if (m_axis_tdata[15:0] !== e.left) begin
						$display("%0t: out_left expected %h got %h", $time, e.left,
							m_axis_tdata[15:0]);
						errors++;
					end
					if (m_axis_tdata[31:16] !== e.right) begin
						$display("%0t: out_right expected %h got %h", $time, e.right,
							m_axis_tdata[31:16]);
						errors++;
					end
				end
				if (beats_out == 400 && !hold_done) begin
					hold_done = 1;
					hold_left = 4000;
				end
			end
			stall_phase = (stall_phase + 1) % 96;
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (stall_phase < 32) begin
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= ($urandom_range(0, 2) != 0);
			end
		end
	end

	// watchdog on cycles without any accepted beat
	int quiet = 0;
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet <= 0;
		else if (quiet >= IDLE_LIMIT) begin
			$display("timeout at %0t", $time);
			$display("tb_top NOT OK");
			$finish;
		end else
			quiet <= quiet + 1;
	end

	function automatic logic [15:0] rand_sample();
		case ($urandom_range(0, 7))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic void add_item(logic [15:0] l, logic [15:0] r, logic [31:0] rw);
		grain_in_t it;
		it.left = l;
		it.right = r;
		it.rnd = rw;
		pending_q.push_back(it);
	endfunction

	// wait for all beats out, then for any fade or search still running
	task automatic drain();
		while (pending_q.size() > 0 || s_axis_tvalid || expected_q.size() > 0)
			@(posedge clk);
		repeat (1000) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val[CFG_W-1:0];
		@(posedge clk);
		wr_en <= 1'b0;
		if (idx == REG_NUM_BINS)
			nb_reg = val[3:0];
		else
			gs_reg = val[14:0];
	endtask

	task automatic run_phase(int nb, int gs, int n);
		int i;
		drain();
		write_reg(REG_NUM_BINS, nb);
		write_reg(REG_GRAIN_SAMPLES, gs);
		for (i = 0; i < n; i++)
			add_item(rand_sample(), rand_sample(), $urandom);
	endtask

	initial begin
		int i;
		for (i = 0; i < BINS*STRIDE; i++)
			store[i] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		// out-of-range settings: clamp to max bins and shortest grain
		write_reg(REG_NUM_BINS, 15);
		write_reg(REG_GRAIN_SAMPLES, 5);
		// directed: sample extremes and random_word extremes
		add_item(16'h7fff, 16'h8000, 32'hffff_ffff);
		add_item(16'h8000, 16'h7fff, 32'h0000_0000);
		add_item(16'h0000, 16'hffff, 32'h0000_0007);
		add_item(16'hffff, 16'h0001, 32'h8000_0000);
		for (i = 0; i < 20; i++)
			add_item(i[0] ? 16'h7fff : 16'h8000, i[0] ? 16'h8000 : 16'h7fff, 32'(i));
		// random phases: single bin, max bins, grain raised and lowered mid-grain
		run_phase(1, 101, 300);
		run_phase(8, 101, 350);
		run_phase(3, 150, 300);
		run_phase(0, 120, 200);
		run_phase(8, 16384, 40);
		run_phase(5, 32767, 30);
		run_phase(2, 101, 300);
		run_phase(7, 130, 380);
		drain();
		$display("%0d beats in, %0d out, %0d grains completed, %0d mismatches",
			beats_in, beats_out, grains_done, errors);
		if (errors == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end
endmodule
`default_nettype wire
